@@ rtl/olad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olad_pkg - ordered list append/delete shared definitions
// list depth, derived widths, command and status codes, command word type
// ----------------------------------------------------------------------------
package olad_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    // command queue between front and back, power of two
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_ENTRY    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

endpackage

@@ rtl/olad_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olad_front - command intake
// accepts command words, drops undefined opcodes, queues the rest for the back
// ----------------------------------------------------------------------------
module olad_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [olad_pkg::OP_W-1:0]      i_opcode,
    input  logic signed [olad_pkg::VAL_W-1:0] i_value,
    output logic                           o_cmd_valid,
    output olad_pkg::t_cmd                 o_cmd,
    input  logic                           i_cmd_ready
);

    olad_pkg::t_cmd                 r_q [olad_pkg::CQ_DEPTH];
    logic [olad_pkg::CQ_AW-1:0]     r_wptr;
    logic [olad_pkg::CQ_AW-1:0]     r_rptr;
    logic [olad_pkg::CQ_CW-1:0]     r_cnt;
    logic [olad_pkg::CQ_CW-1:0]     n_cnt;
    logic                           w_keep;
    logic                           w_pop;
    olad_pkg::t_cmd                 w_in;

    assign full        = (r_cnt == olad_pkg::CQ_CW'(olad_pkg::CQ_DEPTH));
    // opcode 3 is taken from the port but never reaches the back
    assign w_keep      = push && !full && (i_opcode != olad_pkg::OP_UNUSED);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_in.opcode = i_opcode;
        w_in.value  = i_value;
        n_cnt = r_cnt + olad_pkg::CQ_CW'(w_keep) - olad_pkg::CQ_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_keep) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wptr] <= w_in;
        end
    end

endmodule

@@ rtl/olad_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olad_back - list cells and command execution
// row of compare/shift cells, dump sequencer and the result output register
// ----------------------------------------------------------------------------
module olad_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  olad_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_ready,
    output logic                              empty,
    input  logic                              pop,
    output logic [olad_pkg::ST_W-1:0]         o_status,
    output logic signed [olad_pkg::VAL_W-1:0] o_entry,
    output logic                              o_last
);

    localparam int D = olad_pkg::DEPTH;

    logic signed [olad_pkg::VAL_W-1:0] r_cells [D];
    logic signed [olad_pkg::VAL_W-1:0] n_cells [D];
    logic signed [olad_pkg::VAL_W-1:0] w_up    [D];
    logic [olad_pkg::CNT_W-1:0]        r_count, n_count;
    logic                              r_dump_active, n_dump_active;
    logic [olad_pkg::IDX_W-1:0]        r_dump_idx, n_dump_idx;
    logic                              r_ov, n_ov;
    logic [olad_pkg::ST_W-1:0]         r_status, n_status;
    logic signed [olad_pkg::VAL_W-1:0] r_entry, n_entry;
    logic                              r_last, n_last;

    logic [D-1:0] w_match;
    logic [D-1:0] w_lo;
    logic [D-1:0] w_shift;
    logic         w_out_free;
    logic         w_take;
    logic         w_dump_last;

    assign w_out_free  = !r_ov || pop;
    assign o_cmd_ready = w_out_free && !r_dump_active;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_dump_last = ((olad_pkg::CNT_W'(r_dump_idx) + 1'b1) == r_count);

    assign empty    = !r_ov;
    assign o_status = r_status;
    assign o_entry  = r_entry;
    assign o_last   = r_last;

    // every cell compares against the command value at once
    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_match[i] = (olad_pkg::CNT_W'(i) < r_count) && (r_cells[i] == i_cmd.value);
        end
        // lowest match isolated, then every cell at or above it pulls from above
        w_lo    = w_match & (~w_match + D'(1));
        w_shift = ~(w_lo - D'(1));
        for (int i = 0; i < D - 1; i++) begin
            w_up[i] = r_cells[i + 1];
        end
        w_up[D-1] = r_cells[D-1];
    end

    always_comb begin
        n_cells       = r_cells;
        n_count       = r_count;
        n_dump_active = r_dump_active;
        n_dump_idx    = r_dump_idx;
        n_ov          = r_ov && !pop;
        n_status      = r_status;
        n_entry       = r_entry;
        n_last        = r_last;

        if (r_dump_active && w_out_free) begin
            n_ov     = 1'b1;
            n_status = olad_pkg::ST_ENTRY;
            n_entry  = r_cells[r_dump_idx];
            n_last   = w_dump_last;
            if (w_dump_last) begin
                n_dump_active = 1'b0;
            end else begin
                n_dump_idx = r_dump_idx + 1'b1;
            end
        end else if (w_take) begin
            n_entry = '0;
            n_last  = 1'b1;
            unique case (i_cmd.opcode)
                olad_pkg::OP_APPEND: begin
                    n_ov = 1'b1;
                    if (r_count == olad_pkg::CNT_W'(D)) begin
                        n_status = olad_pkg::ST_FULL;
                    end else begin
                        n_status = olad_pkg::ST_DONE;
                        n_count  = r_count + 1'b1;
                        for (int i = 0; i < D; i++) begin
                            if (olad_pkg::CNT_W'(i) == r_count) begin
                                n_cells[i] = i_cmd.value;
                            end
                        end
                    end
                end
                olad_pkg::OP_DELETE: begin
                    n_ov = 1'b1;
                    if (r_count == '0) begin
                        n_status = olad_pkg::ST_EMPTY;
                    end else if (w_match == '0) begin
                        n_status = olad_pkg::ST_NOTFOUND;
                    end else begin
                        n_status = olad_pkg::ST_DONE;
                        n_count  = r_count - 1'b1;
                        for (int i = 0; i < D; i++) begin
                            if (w_shift[i]) begin
                                n_cells[i] = w_up[i];
                            end
                        end
                    end
                end
                olad_pkg::OP_DUMP: begin
                    if (r_count == '0) begin
                        n_ov     = 1'b1;
                        n_status = olad_pkg::ST_EMPTY;
                    end else begin
                        n_dump_active = 1'b1;
                        n_dump_idx    = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_dump_active <= 1'b0;
            r_dump_idx    <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_dump_active <= n_dump_active;
            r_dump_idx    <= n_dump_idx;
            r_ov          <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells  <= n_cells;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_last   <= n_last;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= olad_pkg::CNT_W'(D))
        else $error("list count beyond depth");

    a_dump_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dump_active |-> (olad_pkg::CNT_W'(r_dump_idx) < r_count))
        else $error("dump index outside list");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dump_active && w_out_free && w_dump_last) |=> (!r_dump_active && r_ov && r_last))
        else $error("dump did not close with a last word");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (!$past(r_dump_active) && $past(w_take)))
        else $error("list count moved without a command");

endmodule

@@ rtl/ordered_list_append_delete_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete_core - ordered list with append, delete and dump
// queue-style command input, queue-style result output
// ----------------------------------------------------------------------------
// The list holds up to 16 signed 32-bit words, oldest first, in a row of
// cells that all compare against a delete value at once. Commands enter
// through a two-deep command queue, so the input takes one command per cycle
// while the queue has room. The execution side retires an append or a delete
// once the output register is free and places its single result word there;
// a dump starts the sequencer, which reads the list cells in order and gives
// one result word per entry, the last one marked. A stalled result output
// holds execution back, and commands then wait in the queue.
// Opcode 3 is accepted and produces no result.
module ordered_list_append_delete_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [olad_pkg::OP_W-1:0]         i_opcode,
    input  logic signed [olad_pkg::VAL_W-1:0] i_value,
    output logic                              empty,
    input  logic                              pop,
    output logic [olad_pkg::ST_W-1:0]         o_status,
    output logic signed [olad_pkg::VAL_W-1:0] o_entry,
    output logic                              o_last
);

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    olad_pkg::t_cmd w_cmd;

    olad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    olad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_entry     (o_entry),
        .o_last      (o_last)
    );

endmodule

@@ verif/ordered_list_append_delete_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_delete_core_test - self-checking bench for the list core
// drives append, delete and dump commands with random gaps on both queue
// sides, tracks the list contents and checks every result word in order
// ----------------------------------------------------------------------------
module ordered_list_append_delete_core_test;

    localparam int RANDOM_CMDS  = 83;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [olad_pkg::ST_W-1:0]         status;
        logic signed [olad_pkg::VAL_W-1:0] entry;
        logic                              last;
    } t_result;

    class list_tracker;
        logic signed [olad_pkg::VAL_W-1:0] slots[olad_pkg::DEPTH];
        int                                fill;
        t_result                           pending_words[$];
        int                                errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        function void add_word(logic [olad_pkg::ST_W-1:0] st,
                               logic signed [olad_pkg::VAL_W-1:0] ent,
                               logic lst);
            t_result w;
            w.status = st;
            w.entry  = ent;
            w.last   = lst;
            pending_words.push_back(w);
        endfunction

        // work out the words that an accepted command causes
        function void apply_command(logic [olad_pkg::OP_W-1:0] op,
                                    logic signed [olad_pkg::VAL_W-1:0] val);
            int pos;
            pos = -1;
            case (op)
                olad_pkg::OP_APPEND: begin
                    if (fill >= olad_pkg::DEPTH) begin
                        add_word(olad_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        slots[fill] = val;
                        fill++;
                        add_word(olad_pkg::ST_DONE, '0, 1'b1);
                    end
                end
                olad_pkg::OP_DELETE: begin
                    if (fill == 0) begin
                        add_word(olad_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            if (pos < 0 && slots[i] == val) pos = i;
                        end
                        if (pos < 0) begin
                            add_word(olad_pkg::ST_NOTFOUND, '0, 1'b1);
                        end else begin
                            // later entries close the gap
                            for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
                            fill--;
                            add_word(olad_pkg::ST_DONE, '0, 1'b1);
                        end
                    end
                end
                olad_pkg::OP_DUMP: begin
                    if (fill == 0) begin
                        add_word(olad_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            add_word(olad_pkg::ST_ENTRY, slots[i], (i + 1 == fill));
                        end
                    end
                end
                default: ; // unused opcode gives no word
            endcase
        endfunction

        task check_word(logic [olad_pkg::ST_W-1:0] st,
                        logic signed [olad_pkg::VAL_W-1:0] ent, logic lst);
            t_result w;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word status=%0d entry=%0d last=%0b",
                                 st, ent, lst));
            end else begin
                w = pending_words.pop_front();
                if (st !== w.status)
                    report($sformatf("status %0d, expected %0d", st, w.status));
                if (ent !== w.entry)
                    report($sformatf("entry %0d, expected %0d", ent, w.entry));
                if (lst !== w.last)
                    report($sformatf("last %0b, expected %0b", lst, w.last));
            end
        endtask

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic                              i_clk    = 1'b0;
    logic                              i_rst_n  = 1'b0;
    logic                              push     = 1'b0;
    logic                              pop      = 1'b0;
    logic [olad_pkg::OP_W-1:0]         i_opcode = olad_pkg::OP_APPEND;
    logic signed [olad_pkg::VAL_W-1:0] i_value  = '0;
    logic                              full;
    logic                              empty;
    logic [olad_pkg::ST_W-1:0]         o_status;
    logic signed [olad_pkg::VAL_W-1:0] o_entry;
    logic                              o_last;

    list_tracker tracker = new();
    int          cycles  = 0;

    ordered_list_append_delete_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .empty    (empty),
        .pop      (pop),
        .o_status (o_status),
        .o_entry  (o_entry),
        .o_last   (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // both handshakes sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) tracker.apply_command(i_opcode, i_value);
            if (pop && !empty) tracker.check_word(o_status, o_entry, o_last);
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    bit push_quiet = 1'b0;
    int push_count = 0;

    task automatic send_command(logic [olad_pkg::OP_W-1:0] op,
                                logic signed [olad_pkg::VAL_W-1:0] val);
        int gap;
        if (push_count % 16 == 0) push_quiet = ($urandom_range(0, 2) == 0);
        push_count++;
        gap = draw_gap(push_quiet);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (full);
    endtask

    // result side: random stalls, with stretches of steady popping
    initial begin
        bit quiet;
        int gap;
        int words;
        quiet = 1'b0;
        words = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (words % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
            words++;
            gap = draw_gap(quiet);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        logic [olad_pkg::OP_W-1:0]         op;
        logic signed [olad_pkg::VAL_W-1:0] val;
        bit                                filling;
        int                                r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list cases, extremes, duplicates, full list
        send_command(olad_pkg::OP_DUMP, 32'sd0);
        send_command(olad_pkg::OP_DELETE, 32'sd7);
        send_command(olad_pkg::OP_UNUSED, 32'sd7);
        send_command(olad_pkg::OP_APPEND, 32'sh8000_0000);
        send_command(olad_pkg::OP_APPEND, 32'sh7fff_ffff);
        send_command(olad_pkg::OP_APPEND, 32'sd0);
        send_command(olad_pkg::OP_APPEND, -32'sd1);
        send_command(olad_pkg::OP_APPEND, 32'sh8000_0000);
        send_command(olad_pkg::OP_DELETE, 32'sd12345);
        send_command(olad_pkg::OP_DELETE, 32'sh8000_0000);
        send_command(olad_pkg::OP_DUMP, 32'sd0);
        for (int i = 4; i < olad_pkg::DEPTH; i++) send_command(olad_pkg::OP_APPEND, $urandom);
        send_command(olad_pkg::OP_APPEND, 32'sd99);
        send_command(olad_pkg::OP_DUMP, 32'sd0);
        send_command(olad_pkg::OP_DELETE, -32'sd1);
        send_command(olad_pkg::OP_DELETE, 32'sh7fff_ffff);

        // random: alternate filling and draining so both ends get reached
        filling = 1'b0;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 20 == 0) filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = olad_pkg::OP_UNUSED;
            else if (r < 13)
                op = olad_pkg::OP_DUMP;
            else if (r < (filling ? 78 : 38))
                op = olad_pkg::OP_APPEND;
            else
                op = olad_pkg::OP_DELETE;
            // small value pool so deletes find matches and duplicates occur
            if ($urandom_range(0, 3) == 0) begin
                val = $urandom;
            end else begin
                case ($urandom_range(0, 5))
                    0: val = 32'sh8000_0000;
                    1: val = 32'sh7fff_ffff;
                    2: val = 32'sd0;
                    3: val = -32'sd1;
                    4: val = 32'sd1;
                    default: val = 32'sh5a5a_a5a5;
                endcase
            end
            send_command(op, val);
        end
        push <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d words never arrived", tracker.pending()));

        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
